// ===== rtl/potential_field_steering_macros.svh =====
// Assertion macros for the potential field steering block.
`ifndef POTENTIAL_FIELD_STEERING_MACROS_SVH
`define POTENTIAL_FIELD_STEERING_MACROS_SVH

`ifndef ASSERT_OFF

// Check post in the same cycle whenever pre holds.
`define PFS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("potential_field_steering: assertion failed");

// Check post in the cycle after pre holds.
`define PFS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("potential_field_steering: assertion failed");

`else

`define PFS_ASSERT_NOW(label, pre, post)
`define PFS_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== rtl/pfs_pkg.sv =====
// Types, constants and the arctangent table of the potential field steering block.
`default_nettype none

package pfs_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = 4;
    localparam int CX_W         = 53;
    localparam int CZ_W         = 34;
    localparam int MUL_A_W      = 20;
    localparam int MUL_B_W      = 42;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;

    typedef logic signed [CX_W-1:0]    cvec_t;
    typedef logic signed [CZ_W-1:0]    cang_t;
    typedef logic signed [MUL_P_W-1:0] prod_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CRIT    = 3'd0;
    localparam logic [2:0] REG_WINDOW  = 3'd1;
    localparam logic [2:0] REG_START   = 3'd2;
    localparam logic [2:0] REG_STEP    = 3'd3;
    localparam logic [2:0] REG_WEIGHTS = 3'd4;
    localparam logic [2:0] REG_GAINS   = 3'd5;
    localparam logic [2:0] REG_TOL     = 3'd6;
    localparam logic [2:0] REG_CRUISE  = 3'd7;

    localparam logic signed [MUL_A_W-1:0] INV_GAIN     = 20'sd39797;
    localparam logic signed [MUL_A_W-1:0] THREE_TENTHS = 20'sd19661;
    localparam logic signed [MUL_A_W-1:0] TWO_PI_Q16   = 20'sd411775;
    // Prescaled start length of a unit vector: (65536 * 39797 + 128) >> 8.
    localparam cvec_t UNIT_X0 = 53'sd10188032;

    function automatic logic [31:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            4'd0:  v = 32'h20000000;
            4'd1:  v = 32'h12E4051D;
            4'd2:  v = 32'h09FB385B;
            4'd3:  v = 32'h051111D4;
            4'd4:  v = 32'h028B0D43;
            4'd5:  v = 32'h0145D7E1;
            4'd6:  v = 32'h00A2F61E;
            4'd7:  v = 32'h00517C55;
            4'd8:  v = 32'h0028BE53;
            4'd9:  v = 32'h00145F2E;
            4'd10: v = 32'h000A2F98;
            4'd11: v = 32'h000517CC;
            4'd12: v = 32'h00028BE6;
            4'd13: v = 32'h000145F3;
            4'd14: v = 32'h0000A2F9;
            4'd15: v = 32'h0000517C;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/potential_field_steering.sv =====
// Potential field steering: laser scan repulsion, goal attraction, turn rate and speed.
`default_nettype none

// Range samples of one scan come in one word each, with pose and goal. A beam
// within the valid window and nearer than the critical distance adds a
// repulsion of size (crit - d) / crit, pointed away from the beam, to two
// 32-bit sums. On the word marked tlast the unit goal vector and the weighted
// sum give a desired heading; the heading error sets turn rate and speed, one
// result word goes out, and the scan state clears.
// A beam that adds nothing is taken in the idle state alone; a beam that adds
// repulsion runs the bit-serial divider and then a pass of the shared CORDIC
// unit; the last beam adds up to two vectoring passes and one rotation pass of
// the CORDIC unit plus steps of the shared multiplier.
// The CORDIC shift-add unit and the one multiplier do this work in turn. The
// input is not ready while an item is at work; a finished result sits in an
// output register, so the next beam is taken while it waits.
`include "potential_field_steering_macros.svh"

module potential_field_steering
    import pfs_pkg::*;
#(
    parameter int MAX_BEAMS = 1024
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // range_sample[15:0], robot_x[39:16], robot_y[63:40], robot_heading[79:64],
    // goal_x[103:80], goal_y[127:104]
    input  wire logic [127:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,   // last_beam
    // Output stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // forward_speed[15:0], turn_rate[31:16]
    output logic [31:0]       m_axis_tdata,
    // Configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(MAX_BEAMS + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ANGLE = 5'd1;
    localparam logic [4:0] S_DIV   = 5'd2;
    localparam logic [4:0] S_X0    = 5'd3;
    localparam logic [4:0] S_CORD  = 5'd4;
    localparam logic [4:0] S_CPOST = 5'd5;
    localparam logic [4:0] S_GOAL  = 5'd6;
    localparam logic [4:0] S_VX1   = 5'd7;
    localparam logic [4:0] S_VX2   = 5'd8;
    localparam logic [4:0] S_VY1   = 5'd9;
    localparam logic [4:0] S_VY2   = 5'd10;
    localparam logic [4:0] S_DVEC  = 5'd11;
    localparam logic [4:0] S_ERR   = 5'd12;
    localparam logic [4:0] S_SPD   = 5'd13;
    localparam logic [4:0] S_T1    = 5'd14;
    localparam logic [4:0] S_T2    = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    // What the current CORDIC pass is for.
    localparam logic [1:0] PH_REPULSE = 2'd0;
    localparam logic [1:0] PH_GOALVEC = 2'd1;
    localparam logic [1:0] PH_GOALROT = 2'd2;
    localparam logic [1:0] PH_DESIRED = 2'd3;

    // Configuration registers
    logic [15:0] crit_reg, crit_next;
    logic [31:0] window_reg, window_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] step_reg, step_next;
    logic [31:0] weights_reg, weights_next;
    logic [31:0] gains_reg, gains_next;
    logic [14:0] tol_reg, tol_next;
    logic [15:0] cruise_reg, cruise_next;

    // Scan state and control
    logic [CNT_W-1:0]  beam_count_reg, beam_count_next;
    logic [31:0]       sum_x_reg, sum_x_next;
    logic [31:0]       sum_y_reg, sum_y_next;
    logic [4:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;

    // Payload
    logic [15:0]        d_reg, d_next;
    logic [15:0]        head_reg, head_next;
    logic signed [23:0] rx_reg, rx_next, ry_reg, ry_next;
    logic signed [23:0] gx_reg, gx_next, gy_reg, gy_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   cnt_at_reg, cnt_at_next;
    logic [15:0]        angle_reg, angle_next;
    logic [16:0]        rem_reg, rem_next;
    logic [15:0]        quo_reg, quo_next;
    cvec_t              cx_reg, cx_next, cy_reg, cy_next;
    cang_t              cz_reg, cz_next;
    logic               vec_mode_reg, vec_mode_next;
    logic               neg_reg, neg_next;
    logic signed [18:0] ux_reg, ux_next, uy_reg, uy_next;
    cvec_t              vx_reg, vx_next, acc_reg, acc_next;
    logic signed [31:0] err_reg, err_next;
    logic               near_reg, near_next;
    logic [15:0]        gain_reg, gain_next;
    logic [15:0]        speed_reg, speed_next;
    logic signed [41:0] tprod_reg, tprod_next;
    logic [15:0]        turn_reg, turn_next;
    logic [15:0]        out_speed_reg, out_speed_next;
    logic [15:0]        out_turn_reg, out_turn_next;

    // Input fields
    logic [15:0] in_d;
    logic [15:0] in_head;
    logic        in_hit;
    logic        cnt_lt_max;
    logic        cfg_we;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    prod_t                     mul_p;

    // Shared CORDIC step
    cvec_t cx_step, cy_step, sh_x, sh_y;
    cang_t cz_step, atan_ext;
    logic  ccw;

    // Rotation output rounding
    cvec_t rnd_x, rnd_y, fin_x, fin_y;

    // Angle fold for rotation start
    logic [31:0] fold_src;
    cang_t       fold_z, fold_out;
    logic        fold_neg;

    // Vectoring start
    cvec_t       vin_x, vin_y;
    logic signed [24:0] gdx, gdy;

    // Error and turn math
    logic signed [32:0] err_ext, err_mag;
    logic signed [31:0] e24;
    prod_t              turn_full;
    logic [16:0]        rem_sh;

    assign in_d    = s_axis_tdata[15:0];
    assign in_head = s_axis_tdata[79:64];
    assign cnt_lt_max = beam_count_reg < CNT_W'(MAX_BEAMS);
    assign in_hit = cnt_lt_max
                 && (in_d >= window_reg[15:0]) && (in_d <= window_reg[31:16])
                 && (in_d != 16'd0) && (in_d < crit_reg);
    assign cfg_we = psel & penable & pwrite & pready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_turn_reg, out_speed_reg};
    assign pready        = 1'b1;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_CRIT:    prdata = {16'd0, crit_reg};
            REG_WINDOW:  prdata = window_reg;
            REG_START:   prdata = {16'd0, start_reg};
            REG_STEP:    prdata = {16'd0, step_reg};
            REG_WEIGHTS: prdata = weights_reg;
            REG_GAINS:   prdata = gains_reg;
            REG_TOL:     prdata = {17'd0, tol_reg};
            REG_CRUISE:  prdata = {16'd0, cruise_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Pick the multiplier operands for the step at hand.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ANGLE:
            begin
                mul_a = signed'(MUL_A_W'(cnt_at_reg));
                mul_b = signed'(MUL_B_W'(step_reg));
            end
            S_X0:
            begin
                mul_a = INV_GAIN;
                mul_b = signed'(MUL_B_W'(quo_reg));
            end
            S_VX1:
            begin
                mul_a = signed'(MUL_A_W'(weights_reg[15:0]));
                mul_b = MUL_B_W'(ux_reg);
            end
            S_VX2:
            begin
                mul_a = signed'(MUL_A_W'(weights_reg[31:16]));
                mul_b = MUL_B_W'(signed'(sum_x_reg));
            end
            S_VY1:
            begin
                mul_a = signed'(MUL_A_W'(weights_reg[15:0]));
                mul_b = MUL_B_W'(uy_reg);
            end
            S_VY2:
            begin
                mul_a = signed'(MUL_A_W'(weights_reg[31:16]));
                mul_b = MUL_B_W'(signed'(sum_y_reg));
            end
            S_SPD:
            begin
                mul_a = THREE_TENTHS;
                mul_b = signed'(MUL_B_W'(cruise_reg));
            end
            S_T1:
            begin
                mul_a = signed'(MUL_A_W'(gain_reg));
                mul_b = MUL_B_W'(e24);
            end
            S_T2:
            begin
                mul_a = TWO_PI_Q16;
                mul_b = tprod_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One CORDIC micro-rotation; rotation mode drives z to zero, vectoring mode drives y.
    assign sh_x     = cy_reg >>> iter_reg;
    assign sh_y     = cx_reg >>> iter_reg;
    assign atan_ext = signed'(CZ_W'(atan_lut(iter_reg)));
    assign ccw      = vec_mode_reg ? !(cy_reg > 0) : !cz_reg[CZ_W-1];
    assign cx_step  = ccw ? cx_reg - sh_x : cx_reg + sh_x;
    assign cy_step  = ccw ? cy_reg + sh_y : cy_reg - sh_y;
    assign cz_step  = ccw ? cz_reg - atan_ext : cz_reg + atan_ext;

    assign rnd_x = (cx_reg + cvec_t'(128)) >>> 8;
    assign rnd_y = (cy_reg + cvec_t'(128)) >>> 8;
    assign fin_x = neg_reg ? -rnd_x : rnd_x;
    assign fin_y = neg_reg ? -rnd_y : rnd_y;

    // Fold the start angle into the right half plane.
    assign fold_src = (state_reg == S_X0) ? {angle_reg, 16'h0000} : cz_reg[31:0];
    assign fold_z   = CZ_W'(signed'(fold_src));
    always_comb
    begin
        fold_out = fold_z;
        fold_neg = 1'b0;
        if (fold_z > cang_t'(34'sh0_4000_0000))
        begin
            fold_out = fold_z - cang_t'(34'sh0_8000_0000);
            fold_neg = 1'b1;
        end
        else if (fold_z < -cang_t'(34'sh0_4000_0000))
        begin
            fold_out = fold_z + cang_t'(34'sh0_8000_0000);
            fold_neg = 1'b1;
        end
    end

    assign gdx   = 25'(gx_reg) - 25'(rx_reg);
    assign gdy   = 25'(gy_reg) - 25'(ry_reg);
    assign vin_x = (state_reg == S_GOAL) ? CX_W'(gdx) : vx_reg;
    assign vin_y = (state_reg == S_GOAL) ? CX_W'(gdy) : acc_reg;

    assign err_ext   = 33'(err_reg);
    assign err_mag   = err_ext[32] ? -err_ext : err_ext;
    assign e24       = err_reg >>> 8;
    assign turn_full = (mul_p + prod_t'(62'sd549755813888)) >>> 40;
    assign rem_sh    = {rem_reg[15:0], 1'b0};

    always_comb
    begin
        crit_next       = crit_reg;
        window_next     = window_reg;
        start_next      = start_reg;
        step_next       = step_reg;
        weights_next    = weights_reg;
        gains_next      = gains_reg;
        tol_next        = tol_reg;
        cruise_next     = cruise_reg;
        beam_count_next = beam_count_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        state_next      = state_reg;
        phase_next      = phase_reg;
        iter_next       = iter_reg;
        out_valid_next  = out_valid_reg;
        d_next          = d_reg;
        head_next       = head_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        last_next       = last_reg;
        cnt_at_next     = cnt_at_reg;
        angle_next      = angle_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        vec_mode_next   = vec_mode_reg;
        neg_next        = neg_reg;
        ux_next         = ux_reg;
        uy_next         = uy_reg;
        vx_next         = vx_reg;
        acc_next        = acc_reg;
        err_next        = err_reg;
        near_next       = near_reg;
        gain_next       = gain_reg;
        speed_next      = speed_reg;
        tprod_next      = tprod_reg;
        turn_next       = turn_reg;
        out_speed_next  = out_speed_reg;
        out_turn_next   = out_turn_reg;

        if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_CRIT:    crit_next    = pwdata[15:0];
                REG_WINDOW:  window_next  = pwdata;
                REG_START:   start_next   = pwdata[15:0];
                REG_STEP:    step_next    = pwdata[15:0];
                REG_WEIGHTS: weights_next = pwdata;
                REG_GAINS:   gains_next   = pwdata;
                REG_TOL:     tol_next     = pwdata[14:0];
                REG_CRUISE:  cruise_next  = pwdata[15:0];
                default:     crit_next    = crit_reg;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    d_next      = in_d;
                    head_next   = in_head;
                    rx_next     = s_axis_tdata[39:16];
                    ry_next     = s_axis_tdata[63:40];
                    gx_next     = s_axis_tdata[103:80];
                    gy_next     = s_axis_tdata[127:104];
                    last_next   = s_axis_tlast;
                    cnt_at_next = beam_count_reg;
                    // Saturate the beam counter at the beam limit.
                    if (cnt_lt_max)
                        beam_count_next = beam_count_reg + 1'b1;
                    if (in_hit)
                        state_next = S_ANGLE;
                    else if (s_axis_tlast)
                        state_next = S_GOAL;
                end
            end
            S_ANGLE:
            begin
                // World angle of the beam, turned half a turn to point away.
                angle_next = start_reg + mul_p[15:0] + head_reg + 16'h8000;
                rem_next   = {1'b0, crit_reg - d_reg};
                quo_next   = '0;
                iter_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, crit_reg})
                begin
                    rem_next = rem_sh - {1'b0, crit_reg};
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                    state_next = S_X0;
            end
            S_X0:
            begin
                cx_next       = CX_W'((mul_p + prod_t'(128)) >>> 8);
                cy_next       = '0;
                cz_next       = fold_out;
                neg_next      = fold_neg;
                vec_mode_next = 1'b0;
                iter_next     = '0;
                phase_next    = PH_REPULSE;
                state_next    = S_CORD;
            end
            S_CORD:
            begin
                cx_next   = cx_step;
                cy_next   = cy_step;
                cz_next   = cz_step;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                    state_next = S_CPOST;
            end
            S_CPOST:
            begin
                unique case (phase_reg)
                    PH_REPULSE:
                    begin
                        sum_x_next = sum_x_reg + fin_x[31:0];
                        sum_y_next = sum_y_reg + fin_y[31:0];
                        state_next = last_reg ? S_GOAL : S_IDLE;
                    end
                    PH_GOALVEC:
                    begin
                        cx_next       = UNIT_X0;
                        cy_next       = '0;
                        cz_next       = fold_out;
                        neg_next      = fold_neg;
                        vec_mode_next = 1'b0;
                        iter_next     = '0;
                        phase_next    = PH_GOALROT;
                        state_next    = S_CORD;
                    end
                    PH_GOALROT:
                    begin
                        ux_next    = fin_x[18:0];
                        uy_next    = fin_y[18:0];
                        state_next = S_VX1;
                    end
                    PH_DESIRED:
                    begin
                        err_next   = signed'(cz_reg[31:0] - {head_reg, 16'h0000});
                        state_next = S_ERR;
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_GOAL:
            begin
                if ((gx_reg == rx_reg) && (gy_reg == ry_reg))
                begin
                    // Goal at the robot: no attraction.
                    ux_next    = '0;
                    uy_next    = '0;
                    state_next = S_VX1;
                end
                else
                begin
                    cx_next       = vin_x[CX_W-1] ? -vin_x : vin_x;
                    cy_next       = vin_x[CX_W-1] ? -vin_y : vin_y;
                    cz_next       = vin_x[CX_W-1] ? cang_t'(34'sh0_8000_0000) : '0;
                    vec_mode_next = 1'b1;
                    iter_next     = '0;
                    phase_next    = PH_GOALVEC;
                    state_next    = S_CORD;
                end
            end
            S_VX1:
            begin
                acc_next   = CX_W'(mul_p);
                state_next = S_VX2;
            end
            S_VX2:
            begin
                vx_next    = acc_reg + CX_W'(mul_p);
                state_next = S_VY1;
            end
            S_VY1:
            begin
                acc_next   = CX_W'(mul_p);
                state_next = S_VY2;
            end
            S_VY2:
            begin
                acc_next   = acc_reg + CX_W'(mul_p);
                state_next = S_DVEC;
            end
            S_DVEC:
            begin
                if ((vx_reg == '0) && (acc_reg == '0))
                begin
                    // Zero resulting vector: desired heading 0.
                    err_next   = signed'(32'd0 - {head_reg, 16'h0000});
                    state_next = S_ERR;
                end
                else
                begin
                    cx_next       = vin_x[CX_W-1] ? -vin_x : vin_x;
                    cy_next       = vin_x[CX_W-1] ? -vin_y : vin_y;
                    cz_next       = vin_x[CX_W-1] ? cang_t'(34'sh0_8000_0000) : '0;
                    vec_mode_next = 1'b1;
                    iter_next     = '0;
                    phase_next    = PH_DESIRED;
                    state_next    = S_CORD;
                end
            end
            S_ERR:
            begin
                near_next  = err_mag < signed'({2'b00, tol_reg, 16'h0000});
                gain_next  = (err_mag < signed'({2'b00, tol_reg, 16'h0000}))
                             ? gains_reg[15:0] : gains_reg[31:16];
                state_next = S_SPD;
            end
            S_SPD:
            begin
                speed_next = near_reg ? cruise_reg
                                      : 16'((mul_p + prod_t'(32768)) >>> 16);
                state_next = S_T1;
            end
            S_T1:
            begin
                tprod_next = MUL_B_W'(mul_p);
                state_next = S_T2;
            end
            S_T2:
            begin
                if (turn_full > prod_t'(32767))
                    turn_next = 16'h7FFF;
                else if (turn_full < -prod_t'(32768))
                    turn_next = 16'h8000;
                else
                    turn_next = turn_full[15:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hand the result over once the output register is free, then clear the scan.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_speed_next  = speed_reg;
                    out_turn_next   = turn_reg;
                    beam_count_next = '0;
                    sum_x_next      = '0;
                    sum_y_next      = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_reg       <= 16'd256;
            window_reg     <= 32'h6400_0000;
            start_reg      <= 16'hC000;
            step_reg       <= 16'd64;
            weights_reg    <= 32'h3000_1800;
            gains_reg      <= 32'h1000_0580;
            tol_reg        <= 15'd4174;
            cruise_reg     <= 16'd4096;
            beam_count_reg <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            state_reg      <= S_IDLE;
            phase_reg      <= PH_REPULSE;
            iter_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            crit_reg       <= crit_next;
            window_reg     <= window_next;
            start_reg      <= start_next;
            step_reg       <= step_next;
            weights_reg    <= weights_next;
            gains_reg      <= gains_next;
            tol_reg        <= tol_next;
            cruise_reg     <= cruise_next;
            beam_count_reg <= beam_count_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            iter_reg       <= iter_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg         <= d_next;
        head_reg      <= head_next;
        rx_reg        <= rx_next;
        ry_reg        <= ry_next;
        gx_reg        <= gx_next;
        gy_reg        <= gy_next;
        last_reg      <= last_next;
        cnt_at_reg    <= cnt_at_next;
        angle_reg     <= angle_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        vec_mode_reg  <= vec_mode_next;
        neg_reg       <= neg_next;
        ux_reg        <= ux_next;
        uy_reg        <= uy_next;
        vx_reg        <= vx_next;
        acc_reg       <= acc_next;
        err_reg       <= err_next;
        near_reg      <= near_next;
        gain_reg      <= gain_next;
        speed_reg     <= speed_next;
        tprod_reg     <= tprod_next;
        turn_reg      <= turn_next;
        out_speed_reg <= out_speed_next;
        out_turn_reg  <= out_turn_next;
    end

    // The beam counter never passes its limit.
    `PFS_ASSERT_NOW(a_count_bound, 1'b1, beam_count_reg <= CNT_W'(MAX_BEAMS))
    // The divider remainder stays below the divisor.
    `PFS_ASSERT_NOW(a_div_rem, state_reg == S_DIV, rem_reg < 17'(crit_reg))
    // Handing over a result clears the scan state.
    `PFS_ASSERT_NEXT(a_out_clear, (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready), m_axis_tvalid && (beam_count_reg == '0) && (sum_x_reg == '0) && (sum_y_reg == '0))

endmodule

`default_nettype wire
